FILE: src/icmp64x_pkg.sv
// Shared types and constants for the ICMPv6 to ICMPv4 header translator.
// No dependencies; imported by every module of the block.

package icmp64x_pkg;

    // ICMPv6 message types
    localparam logic [7:0] V6_DEST_UNREACH   = 8'd1;
    localparam logic [7:0] V6_PKT_TOO_BIG    = 8'd2;
    localparam logic [7:0] V6_TIME_EXCEEDED  = 8'd3;
    localparam logic [7:0] V6_PARAM_PROBLEM  = 8'd4;
    localparam logic [7:0] V6_ECHO_REQUEST   = 8'd128;
    localparam logic [7:0] V6_ECHO_REPLY     = 8'd129;

    // ICMPv6 codes used by the translation rules
    localparam logic [7:0] V6C_NO_ROUTE      = 8'd0;
    localparam logic [7:0] V6C_ADMIN_PROHIB  = 8'd1;
    localparam logic [7:0] V6C_BEYOND_SCOPE  = 8'd2;
    localparam logic [7:0] V6C_ADDR_UNREACH  = 8'd3;
    localparam logic [7:0] V6C_PORT_UNREACH  = 8'd4;
    localparam logic [7:0] V6C_REASSEMBLY    = 8'd1;
    localparam logic [7:0] V6C_BAD_HDR_FIELD = 8'd0;
    localparam logic [7:0] V6C_BAD_NEXT_HDR  = 8'd1;

    // ICMPv4 message types
    localparam logic [7:0] V4_ECHO_REPLY     = 8'd0;
    localparam logic [7:0] V4_DEST_UNREACH   = 8'd3;
    localparam logic [7:0] V4_ECHO_REQUEST   = 8'd8;
    localparam logic [7:0] V4_TIME_EXCEEDED  = 8'd11;
    localparam logic [7:0] V4_PARAM_PROBLEM  = 8'd12;

    // ICMPv4 destination unreachable codes
    localparam logic [7:0] V4_CODE_HOST_UNREACH  = 8'd1;
    localparam logic [7:0] V4_CODE_PROTO_UNREACH = 8'd2;
    localparam logic [7:0] V4_CODE_PORT_UNREACH  = 8'd3;
    localparam logic [7:0] V4_CODE_FRAG_NEEDED   = 8'd4;
    localparam logic [7:0] V4_CODE_HOST_ADMIN    = 8'd10;

    // Generic zero code
    localparam logic [7:0] CODE_ZERO = 8'd0;

    // Length and MTU figures
    localparam logic [15:0] MIN_MSG_LEN     = 16'd8;
    localparam logic [15:0] HDR_LEN_DELTA   = 16'd20;
    localparam logic [15:0] IPV4_MIN_MTU    = 16'd68;
    localparam logic [15:0] MTU_RESET       = 16'd1500;

    // Configuration register indexes
    localparam logic REG_IPV4_OUT_MTU = 1'b0;
    localparam logic REG_IPV6_OUT_MTU = 1'b1;

    // Outbound MTUs as seen by the datapath
    typedef struct packed {
        logic [15:0] ipv6_out_mtu;
        logic [15:0] ipv4_out_mtu;
    } t_mtu_cfg;

    // One ICMPv6 header item
    typedef struct packed {
        logic [15:0] msg_length;
        logic [31:0] v6_rest;
        logic [7:0]  v6_code;
        logic [7:0]  v6_type;
    } t_v6_hdr;

    // One translated result item
    typedef struct packed {
        logic        inner_dont_fragment;
        logic        carries_inner_packet;
        logic [31:0] v4_rest;
        logic [7:0]  v4_code;
        logic [7:0]  v4_type;
        logic        accepted;
    } t_xlat_res;

endpackage

FILE: src/icmpv6_to_icmpv4_header_xlat.sv
// ICMPv6 to ICMPv4 header translator, top level.
// Stages: input register, rewrite logic, result register; an accepted item passes
// through both registers before it is offered on the output.
// Throughput: one item per cycle unless the output stalls.
// Stalls on the output back up through both registers; no items are dropped.
// Reset (synchronous, active low) empties both stages and sets both MTUs to 1500.
// Depends on icmp64x_pkg, icmp64x_cfg_regs and icmp64x_xlat_core.

module icmpv6_to_icmpv4_header_xlat (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // v6_type, v6_code, v6_rest, msg_length
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // v4_type, v4_code, v4_rest
    output logic [2:0]  m_axis_tuser,   // accepted, carries_inner_packet, inner_dont_fragment
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import icmp64x_pkg::*;

    t_mtu_cfg  w_cfg;
    t_v6_hdr   r_in;
    logic      r_in_valid;
    t_xlat_res n_out;
    t_xlat_res r_out;
    logic      r_out_valid;
    logic      w_out_ready;
    logic      w_in_ready;

    icmp64x_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // each stage moves on when the one after it is empty or draining
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_in_ready    = !r_in_valid || w_out_ready;
    assign s_axis_tready = w_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_in_ready) begin
            r_in <= t_v6_hdr'(s_axis_tdata);
        end
    end

    icmp64x_xlat_core u_core (
        .i_hdr (r_in),
        .i_cfg (w_cfg),
        .o_res (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_out_ready) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.v4_rest, r_out.v4_code, r_out.v4_type};
    assign m_axis_tuser  = {r_out.inner_dont_fragment, r_out.carries_inner_packet,
                            r_out.accepted};

    // a rejected item carries nothing but the flag
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.accepted) |->
            (r_out.v4_type == 8'd0 && r_out.v4_code == 8'd0 && r_out.v4_rest == 32'd0
             && !r_out.carries_inner_packet && !r_out.inner_dont_fragment))
        else $error("rejected item with non-zero fields");

    // DF only on accepted error messages
    a_df_implies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.inner_dont_fragment) |->
            (r_out.accepted && r_out.carries_inner_packet))
        else $error("dont-fragment on a non-error item");

    // clamped MTU never falls under the IPv4 minimum
    a_mtu_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.inner_dont_fragment) |->
            (r_out.v4_rest[31:16] == 16'd0 && r_out.v4_rest[15:0] >= IPV4_MIN_MTU))
        else $error("packet too big MTU out of range");

    // a new item never lands on a held input register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && r_in_valid) |-> w_out_ready)
        else $error("input register overwritten while stalled");

    // an item in the input stage reaches the result register when it is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_ready) |=> r_out_valid)
        else $error("item lost between stages");

endmodule

FILE: src/icmp64x_cfg_regs.sv
// APB register file for the outbound MTU settings.
// Depends on icmp64x_pkg.

module icmp64x_cfg_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output icmp64x_pkg::t_mtu_cfg  o_cfg
);
    import icmp64x_pkg::*;

    logic [15:0] r_v4_mtu;
    logic [15:0] r_v6_mtu;
    logic        w_wr;

    // registers are word aligned; paddr[2] picks the register
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4_mtu <= MTU_RESET;
            r_v6_mtu <= MTU_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_IPV4_OUT_MTU: r_v4_mtu <= pwdata[15:0];
                REG_IPV6_OUT_MTU: r_v6_mtu <= pwdata[15:0];
                default:          r_v4_mtu <= r_v4_mtu;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_IPV4_OUT_MTU: prdata = {16'd0, r_v4_mtu};
            REG_IPV6_OUT_MTU: prdata = {16'd0, r_v6_mtu};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.ipv4_out_mtu = r_v4_mtu;
    assign o_cfg.ipv6_out_mtu = r_v6_mtu;

endmodule

FILE: src/icmp64x_xlat_core.sv
// Combinational ICMPv6 to ICMPv4 type, code and rest-of-header rewrite.
// Depends on icmp64x_pkg.

module icmp64x_xlat_core (
    input  icmp64x_pkg::t_v6_hdr   i_hdr,
    input  icmp64x_pkg::t_mtu_cfg  i_cfg,
    output icmp64x_pkg::t_xlat_res o_res
);
    import icmp64x_pkg::*;

    // IPv4 header offsets for remapped parameter problem pointers
    localparam logic [7:0] PTR_VER_IHL  = 8'd0;
    localparam logic [7:0] PTR_TOS      = 8'd1;
    localparam logic [7:0] PTR_TOT_LEN  = 8'd2;
    localparam logic [7:0] PTR_TTL      = 8'd8;
    localparam logic [7:0] PTR_PROTO    = 8'd9;
    localparam logic [7:0] PTR_SRC_ADDR = 8'd12;
    localparam logic [7:0] PTR_DST_ADDR = 8'd16;

    logic [7:0]  w_t;
    logic [7:0]  w_c;
    logic [31:0] w_rest;
    logic        w_tc_ok;
    logic [7:0]  w_nt;
    logic [7:0]  w_nc;
    logic        w_ptr_ok;
    logic [7:0]  w_ptr;
    logic [15:0] w_mtu_sub;
    logic [15:0] w_mtu_v4;
    logic [15:0] w_v6_lim;
    logic [15:0] w_mtu_v6;
    logic [15:0] w_mtu_fin;
    logic        w_rest_ok;
    logic [31:0] w_nr;
    logic        w_ok;
    logic        w_echo;

    assign w_t    = i_hdr.v6_type;
    assign w_c    = i_hdr.v6_code;
    assign w_rest = i_hdr.v6_rest;

    // type and code mapping
    always_comb begin
        w_tc_ok = 1'b0;
        w_nt    = CODE_ZERO;
        w_nc    = CODE_ZERO;
        unique case (w_t)
            V6_ECHO_REQUEST: begin
                w_tc_ok = (w_c == CODE_ZERO);
                w_nt    = V4_ECHO_REQUEST;
            end
            V6_ECHO_REPLY: begin
                w_tc_ok = (w_c == CODE_ZERO);
                w_nt    = V4_ECHO_REPLY;
            end
            V6_DEST_UNREACH: begin
                w_nt = V4_DEST_UNREACH;
                case (w_c) inside
                    V6C_NO_ROUTE, V6C_BEYOND_SCOPE, V6C_ADDR_UNREACH: begin
                        w_tc_ok = 1'b1;
                        w_nc    = V4_CODE_HOST_UNREACH;
                    end
                    V6C_ADMIN_PROHIB: begin
                        w_tc_ok = 1'b1;
                        w_nc    = V4_CODE_HOST_ADMIN;
                    end
                    V6C_PORT_UNREACH: begin
                        w_tc_ok = 1'b1;
                        w_nc    = V4_CODE_PORT_UNREACH;
                    end
                    default: w_tc_ok = 1'b0;
                endcase
            end
            V6_PKT_TOO_BIG: begin
                w_tc_ok = (w_c == CODE_ZERO);
                w_nt    = V4_DEST_UNREACH;
                w_nc    = V4_CODE_FRAG_NEEDED;
            end
            V6_TIME_EXCEEDED: begin
                w_tc_ok = (w_c[7:1] == 7'd0);
                w_nt    = V4_TIME_EXCEEDED;
                w_nc    = w_c;
            end
            V6_PARAM_PROBLEM: begin
                if (w_c == V6C_BAD_HDR_FIELD) begin
                    w_tc_ok = 1'b1;
                    w_nt    = V4_PARAM_PROBLEM;
                end else if (w_c == V6C_BAD_NEXT_HDR) begin
                    w_tc_ok = 1'b1;
                    w_nt    = V4_DEST_UNREACH;
                    w_nc    = V4_CODE_PROTO_UNREACH;
                end
            end
            default: w_tc_ok = 1'b0;
        endcase
    end

    // pointer remap, IPv6 header offset to IPv4 header offset
    always_comb begin
        w_ptr_ok = 1'b1;
        w_ptr    = PTR_VER_IHL;
        case (w_rest[7:0]) inside
            8'd0:          w_ptr = PTR_VER_IHL;
            8'd1:          w_ptr = PTR_TOS;
            8'd4, 8'd5:    w_ptr = PTR_TOT_LEN;
            8'd6:          w_ptr = PTR_PROTO;
            8'd7:          w_ptr = PTR_TTL;
            [8'd8:8'd23]:  w_ptr = PTR_SRC_ADDR;
            [8'd24:8'd39]: w_ptr = PTR_DST_ADDR;
            default:       w_ptr_ok = 1'b0;
        endcase
    end

    // MTU clamp: less the header growth, limited by both outbound MTUs, floor 68
    assign w_mtu_sub = (w_rest[15:0] > HDR_LEN_DELTA) ? (w_rest[15:0] - HDR_LEN_DELTA)
                                                      : 16'd0;
    assign w_mtu_v4  = (w_mtu_sub > i_cfg.ipv4_out_mtu) ? i_cfg.ipv4_out_mtu : w_mtu_sub;
    assign w_v6_lim  = (i_cfg.ipv6_out_mtu >= HDR_LEN_DELTA)
                     ? (i_cfg.ipv6_out_mtu - HDR_LEN_DELTA) : 16'd0;
    assign w_mtu_v6  = (w_mtu_v4 > w_v6_lim) ? w_v6_lim : w_mtu_v4;
    assign w_mtu_fin = (w_mtu_v6 < IPV4_MIN_MTU) ? IPV4_MIN_MTU : w_mtu_v6;

    // rest-of-header rewrite
    always_comb begin
        w_rest_ok = 1'b0;
        w_nr      = 32'd0;
        if (w_t == V6_ECHO_REQUEST || w_t == V6_ECHO_REPLY) begin
            w_rest_ok = 1'b1;
            w_nr      = w_rest;
        end else if (w_t == V6_PKT_TOO_BIG) begin
            w_rest_ok = (w_rest[31:16] == 16'd0);
            w_nr      = {16'd0, w_mtu_fin};
        end else if (w_t == V6_PARAM_PROBLEM) begin
            if (w_c == V6C_BAD_HDR_FIELD) begin
                w_rest_ok = (w_rest[31:8] == 24'd0) && w_ptr_ok;
                w_nr      = {w_ptr, 24'd0};
            end else begin
                w_rest_ok = 1'b1;
            end
        end else begin
            // plain errors must carry an unused, all-zero field
            w_rest_ok = (w_rest == 32'd0);
        end
    end

    assign w_ok   = (i_hdr.msg_length >= MIN_MSG_LEN) && w_tc_ok && w_rest_ok;
    assign w_echo = (w_t == V6_ECHO_REQUEST) || (w_t == V6_ECHO_REPLY);

    // rejected items give all-zero fields
    assign o_res.accepted             = w_ok;
    assign o_res.v4_type              = w_ok ? w_nt : 8'd0;
    assign o_res.v4_code              = w_ok ? w_nc : 8'd0;
    assign o_res.v4_rest              = w_ok ? w_nr : 32'd0;
    assign o_res.carries_inner_packet = w_ok && !w_echo;
    assign o_res.inner_dont_fragment  = w_ok && (w_t == V6_PKT_TOO_BIG);

endmodule
